// ----- hdl/tkls_pkg.sv -----
// Shared types, constants and the value ordering function for the top-k selector.
// Used by tkls_row, tkls_ctrl and top_k_logit_select; depends on nothing.
package tkls_pkg;

  localparam int MAX_KEEP   = 64;
  localparam int unsigned MAX_ITEMS = 32'd16777216;
  localparam int FILL_W     = $clog2(MAX_KEEP + 1);
  localparam int RANK_W     = $clog2(MAX_KEEP);
  localparam int COUNT_W    = $clog2(MAX_ITEMS);
  localparam int INDEX_W    = 24;
  localparam int VALUE_W    = 32;
  localparam int KEY_W      = 32;
  localparam int KEEP_W     = 7;
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(32);

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] element_index;
    logic [VALUE_W-1:0] kept_value;
    logic [RANK_W-1:0]  rank;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] bits;
    logic [INDEX_W-1:0] index;
    logic [KEY_W-1:0]   key;
  } cell_t;

  // Commands from the controller to the cell row.
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } row_cmd_t;

  // Status from the cell row to the controller.
  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } row_status_t;

  // Monotone unsigned key: every NaN maps to zero, both zeros share one key,
  // and larger numbers get larger keys.
  function automatic logic [KEY_W-1:0] order_key(logic [VALUE_W-1:0] b);
    logic [KEY_W-1:0] k;
    if (b[30:0] > 31'h7F80_0000) begin
      k = '0;
    end else if (b[30:0] == 31'h0) begin
      k = 32'h8000_0001;
    end else if (b[31]) begin
      k = ~b + 32'd1;
    end else begin
      k = {1'b1, b[30:0]} + 32'd1;
    end
    return k;
  endfunction

endpackage

// ----- hdl/tkls_row.sv -----
// Datapath of the top-k selector: a sorted row of compare-and-shift cells,
// the fill count and the element counter. Depends on tkls_pkg.
module tkls_row (
  input  logic                      clk,
  input  logic                      rst,
  input  tkls_pkg::row_cmd_t        cmd,
  input  logic [tkls_pkg::VALUE_W-1:0] new_bits,
  output tkls_pkg::row_status_t     status,
  output tkls_pkg::cell_t           head
);

  tkls_pkg::cell_t                   cells [tkls_pkg::MAX_KEEP];
  tkls_pkg::cell_t                   cells_next [tkls_pkg::MAX_KEEP];
  logic [tkls_pkg::MAX_KEEP-1:0]     valid;
  logic [tkls_pkg::MAX_KEEP-1:0]     valid_next;
  logic [tkls_pkg::MAX_KEEP-1:0]     take;
  logic [tkls_pkg::FILL_W-1:0]       fill;
  logic [tkls_pkg::FILL_W-1:0]       fill_next;
  logic [tkls_pkg::COUNT_W-1:0]      element_counter;
  logic [tkls_pkg::COUNT_W-1:0]      element_counter_next;
  tkls_pkg::cell_t                   new_cell;

  // The reported index is the saturating element counter, which is as wide as the index.
  always_comb begin
    new_cell.bits  = new_bits;
    new_cell.index = tkls_pkg::INDEX_W'(element_counter);
    new_cell.key   = tkls_pkg::order_key(new_bits);
  end

  // A cell yields its place when it is empty or holds a strictly smaller key,
  // so equal keys keep arrival order.
  always_comb begin
    for (int i = 0; i < tkls_pkg::MAX_KEEP; i++) begin
      take[i] = !valid[i] || (new_cell.key > cells[i].key);
    end
  end

  always_comb begin
    cells_next = cells;
    valid_next = valid;
    fill_next  = fill;
    element_counter_next = element_counter;
    if (cmd.clear) begin
      valid_next = '0;
      fill_next  = '0;
      element_counter_next = '0;
    end else if (cmd.insert) begin
      if (take[0]) begin
        cells_next[0] = new_cell;
        valid_next[0] = 1'b1;
      end
      for (int i = 1; i < tkls_pkg::MAX_KEEP; i++) begin
        if (take[i]) begin
          if (take[i-1]) begin
            cells_next[i] = cells[i-1];
            valid_next[i] = valid[i-1];
          end else begin
            cells_next[i] = new_cell;
            valid_next[i] = 1'b1;
          end
        end
      end
      if (fill != tkls_pkg::FILL_W'(tkls_pkg::MAX_KEEP)) begin
        fill_next = fill + 1'b1;
      end
      if (element_counter != tkls_pkg::COUNT_W'(tkls_pkg::MAX_ITEMS - 1)) begin
        element_counter_next = element_counter + 1'b1;
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < tkls_pkg::MAX_KEEP - 1; i++) begin
        cells_next[i] = cells[i+1];
        valid_next[i] = valid[i+1];
      end
      valid_next[tkls_pkg::MAX_KEEP-1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (rst) begin
      valid <= '0;
      fill <= '0;
      element_counter <= '0;
    end else begin
      valid <= valid_next;
      fill <= fill_next;
      element_counter <= element_counter_next;
    end
  end

  assign status.fill = fill;
  assign head = cells[0];

endmodule

// ----- hdl/tkls_ctrl.sv -----
// Controller of the top-k selector: keep_count register, insert/emit state
// machine and the rank counter. Depends on tkls_pkg.
module tkls_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         is_last,
  input  logic                         keep_count_we,
  input  logic [tkls_pkg::KEEP_W-1:0]  keep_count_wdata,
  input  tkls_pkg::row_status_t        status,
  output tkls_pkg::row_cmd_t           cmd,
  output logic                         busy,
  output logic                         result_valid,
  output logic [tkls_pkg::RANK_W-1:0]  rank,
  output logic                         final_result
);

  typedef enum logic [1:0] {
    IDLE = 2'b01,
    EMIT = 2'b10
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [tkls_pkg::KEEP_W-1:0]   keep_count;
  logic [tkls_pkg::RANK_W-1:0]   rank_next;
  logic [tkls_pkg::RANK_W-1:0]   last_rank;
  logic [tkls_pkg::RANK_W-1:0]   last_rank_next;
  logic [tkls_pkg::FILL_W-1:0]   fill_after;
  logic [tkls_pkg::FILL_W-1:0]   keep_eff;
  logic [tkls_pkg::FILL_W-1:0]   emit_count;
  logic                          accept;

  assign accept = start && (state == IDLE);

  // Number of results for this vector: the clamped keep count against the
  // fill level that the final insertion leaves.
  always_comb begin
    if (status.fill == tkls_pkg::FILL_W'(tkls_pkg::MAX_KEEP)) begin
      fill_after = status.fill;
    end else begin
      fill_after = status.fill + 1'b1;
    end
    if (keep_count == '0) begin
      keep_eff = tkls_pkg::FILL_W'(1);
    end else if (tkls_pkg::FILL_W'(keep_count) > tkls_pkg::FILL_W'(tkls_pkg::MAX_KEEP)) begin
      keep_eff = tkls_pkg::FILL_W'(tkls_pkg::MAX_KEEP);
    end else begin
      keep_eff = tkls_pkg::FILL_W'(keep_count);
    end
    emit_count = (keep_eff < fill_after) ? keep_eff : fill_after;
  end

  always_comb begin
    state_next     = state;
    rank_next      = rank;
    last_rank_next = last_rank;
    cmd            = '0;
    result_valid   = 1'b0;
    case (state)
      IDLE: begin
        if (accept) begin
          cmd.insert = 1'b1;
          if (is_last) begin
            state_next     = EMIT;
            rank_next      = '0;
            last_rank_next = tkls_pkg::RANK_W'(emit_count - 1'b1);
          end
        end
      end
      EMIT: begin
        result_valid = 1'b1;
        cmd.shift    = 1'b1;
        rank_next    = rank + 1'b1;
        if (rank == last_rank) begin
          cmd.clear  = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rank      <= rank_next;
    last_rank <= last_rank_next;
    if (rst) begin
      state      <= IDLE;
      keep_count <= tkls_pkg::KEEP_RESET;
    end else begin
      state <= state_next;
      if (keep_count_we) begin
        keep_count <= keep_count_wdata;
      end
    end
  end

  assign busy         = (state != IDLE);
  assign final_result = (rank == last_rank);

endmodule

// ----- hdl/top_k_logit_select.sv -----
// Top-k selector: reports the largest single-precision values of a vector in
// descending order. An item is inserted at the edge that accepts it; after
// the last item the n results follow from the next cycle, one per cycle.
// One item per cycle is taken while idle; busy is high while the n results are
// emitted, n being the lesser of the clamped keep count and the items seen. The receiver
// cannot stall. Reset (rst, synchronous) empties the row and sets keep_count to 32.
module top_k_logit_select (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  tkls_pkg::in_item_t           item,
  output logic                         result_valid,
  output tkls_pkg::out_item_t          result,
  input  logic                         keep_count_we,
  input  logic [tkls_pkg::KEEP_W-1:0]  keep_count_wdata
);

  // Command and status between the controller and the cell row.
  tkls_pkg::row_cmd_t              cmd;
  tkls_pkg::row_status_t           status;
  tkls_pkg::cell_t                 head;
  logic [tkls_pkg::RANK_W-1:0]     rank;
  logic                            final_result;

  // The controller owns the keep_count register and sequences each transfer:
  // an accepted item becomes one insert command, and the last item of a
  // vector starts the emit phase, during which busy holds off new items.
  tkls_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .is_last          (item.is_last),
    .keep_count_we    (keep_count_we),
    .keep_count_wdata (keep_count_wdata),
    .status           (status),
    .cmd              (cmd),
    .busy             (busy),
    .result_valid     (result_valid),
    .rank             (rank),
    .final_result     (final_result)
  );

  // The row keeps up to MAX_KEEP values sorted, largest in the head cell.
  // During the emit phase it shifts toward the head once per result, and it
  // clears together with the element counter on the final result.
  tkls_row u_row (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .new_bits (item.value_bits),
    .status   (status),
    .head     (head)
  );

  // Each result comes straight from the registered head cell and the
  // registered rank counter, so it stands for exactly its strobe cycle.
  always_comb begin
    result.element_index = head.index;
    result.kept_value    = head.bits;
    result.rank          = rank;
    result.final_result  = final_result;
  end

endmodule
